>>> rtl/cur_ovl_pkg.sv
// Shared constants and types for the cursor overlay compositor.
package cur_ovl_pkg;

  // Cursor bitmap geometry
  localparam int MAX_CURSOR_WIDTH  = 32;
  localparam int MAX_CURSOR_HEIGHT = 32;
  localparam int COL_W    = (MAX_CURSOR_WIDTH > 1) ? $clog2(MAX_CURSOR_WIDTH) : 1;
  localparam int ROW_W    = (MAX_CURSOR_HEIGHT > 1) ? $clog2(MAX_CURSOR_HEIGHT) : 1;
  localparam int BMP_DEPTH = MAX_CURSOR_WIDTH * MAX_CURSOR_HEIGHT;
  localparam int BMP_ADDR_W = (BMP_DEPTH > 1) ? $clog2(BMP_DEPTH) : 1;

  // Field widths
  localparam int POS_W   = 12;
  localparam int PIX_W   = 32;
  localparam int CRD_W   = 13;
  localparam int DIFF_W  = CRD_W + 1;
  localparam int SIZE_W  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 2 * POS_W + PIX_W;

  // Pixel constants
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [15:0] BLEND_ROUND  = 16'd127;

  // Request kinds carried on in_tuser
  typedef enum logic {
    REQ_LOAD      = 1'b0,
    REQ_COMPOSITE = 1'b1
  } req_type_t;

  // Configuration register indices
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURSOR_X      = 3'd0,
    CFG_CURSOR_Y      = 3'd1,
    CFG_CURSOR_WIDTH  = 3'd2,
    CFG_CURSOR_HEIGHT = 3'd3,
    CFG_KEY_COLOR     = 3'd4,
    CFG_VISIBLE       = 3'd5,
    CFG_BG_RGB565     = 3'd6
  } cfg_idx_t;

  // What the final stage selects
  typedef enum logic [1:0] {
    MODE_BG    = 2'd0,
    MODE_WORD  = 2'd1,
    MODE_BLEND = 2'd2
  } comp_mode_t;

endpackage

>>> rtl/cur_ovl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module cur_ovl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/cursor_overlay_compositor_top.sv
// Cursor overlay: bitmap store, rectangle test, colour key and alpha blend.
// A composite beat goes through the stage 1, stage 2 and output registers to out_*.
// Throughput: one beat per cycle, loads and composites alike, while not stalled by
// out_tready; the bitmap RAM has separate write and read ports, so a load and a
// later read never collide. Reset (rst_n low, synchronous) clears the configuration
// and all valid flags; the bitmap keeps undefined contents until loaded.
module cursor_overlay_compositor_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // input beats
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [cur_ovl_pkg::IN_DATA_W-1:0]   in_tdata,  // pos_x, pos_y, pixel_word
  input  logic                                in_tuser,  // req_type
  // result beats
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cur_ovl_pkg::PIX_W-1:0]       out_tdata, // out_pixel
  output logic                                out_tuser, // cursor_hit
  // configuration writes
  input  logic                                cfg_we,
  input  logic [cur_ovl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cur_ovl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // ---- helpers ----
  function automatic logic [31:0] expand_565(input logic [15:0] w);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    r = w[15:11];
    g = w[10:5];
    b = w[4:0];
    return {cur_ovl_pkg::ALPHA_OPAQUE, r, r[4:2], g, g[5:4], b, b[4:2]};
  endfunction

  function automatic logic [15:0] blend_sum(input logic [7:0] fg, input logic [7:0] bg,
                                            input logic [7:0] a);
    logic [15:0] pf;
    logic [15:0] pb;
    pf = {8'd0, fg} * {8'd0, a};
    pb = {8'd0, bg} * {8'd0, cur_ovl_pkg::ALPHA_OPAQUE - a};
    return pf + pb + cur_ovl_pkg::BLEND_ROUND;
  endfunction

  // divide by 255, exact for sums below 65280
  function automatic logic [7:0] div255(input logic [15:0] s);
    logic [16:0] t;
    t = {1'b0, s} + {9'd0, s[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  // ---- configuration registers ----
  logic signed [cur_ovl_pkg::CRD_W-1:0]  cursor_x_r, cursor_y_r;
  logic [cur_ovl_pkg::SIZE_W-1:0]        cursor_width_r, cursor_height_r;
  logic [cur_ovl_pkg::PIX_W-1:0]         key_color_r;
  logic                                  cursor_visible_r, bg_rgb565_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r       <= '0;
      cursor_y_r       <= '0;
      cursor_width_r   <= '0;
      cursor_height_r  <= '0;
      key_color_r      <= '0;
      cursor_visible_r <= 1'b0;
      bg_rgb565_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cur_ovl_pkg::cfg_idx_t'(cfg_index))
        cur_ovl_pkg::CFG_CURSOR_X:      cursor_x_r <= cfg_wdata[cur_ovl_pkg::CRD_W-1:0];
        cur_ovl_pkg::CFG_CURSOR_Y:      cursor_y_r <= cfg_wdata[cur_ovl_pkg::CRD_W-1:0];
        cur_ovl_pkg::CFG_CURSOR_WIDTH:  cursor_width_r <= cfg_wdata[cur_ovl_pkg::SIZE_W-1:0];
        cur_ovl_pkg::CFG_CURSOR_HEIGHT: cursor_height_r <= cfg_wdata[cur_ovl_pkg::SIZE_W-1:0];
        cur_ovl_pkg::CFG_KEY_COLOR:     key_color_r <= cfg_wdata[cur_ovl_pkg::PIX_W-1:0];
        cur_ovl_pkg::CFG_VISIBLE:       cursor_visible_r <= cfg_wdata[0];
        cur_ovl_pkg::CFG_BG_RGB565:     bg_rgb565_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---- pipeline enables (bubbles collapse) ----
  logic v1_r, v2_r, out_valid_r;
  logic en_out, en2, en1;

  assign en_out    = !out_valid_r || out_tready;
  assign en2       = !v2_r || en_out;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  // ---- stage 0: field unpack, rectangle test, RGB565 expand, RAM addressing ----
  logic [cur_ovl_pkg::POS_W-1:0]      in_pos_x, in_pos_y;
  logic [cur_ovl_pkg::PIX_W-1:0]      in_pixel_word;
  logic                               in_acc, is_load, is_comp;
  logic [cur_ovl_pkg::SIZE_W-1:0]     w_eff, h_eff;
  logic signed [cur_ovl_pkg::DIFF_W-1:0] dx, dy;
  logic                               hit0;
  logic [cur_ovl_pkg::PIX_W-1:0]      bg0;
  logic                               ram_we;
  logic [cur_ovl_pkg::BMP_ADDR_W-1:0] ram_waddr, ram_raddr;

  assign in_pos_x      = in_tdata[cur_ovl_pkg::POS_W-1:0];
  assign in_pos_y      = in_tdata[2*cur_ovl_pkg::POS_W-1:cur_ovl_pkg::POS_W];
  assign in_pixel_word = in_tdata[cur_ovl_pkg::IN_DATA_W-1:2*cur_ovl_pkg::POS_W];
  assign in_acc        = in_tvalid && in_tready;
  assign is_load       = (cur_ovl_pkg::req_type_t'(in_tuser) == cur_ovl_pkg::REQ_LOAD);
  assign is_comp       = (cur_ovl_pkg::req_type_t'(in_tuser) == cur_ovl_pkg::REQ_COMPOSITE);

  always_comb begin
    // clamp sizes to the bitmap
    w_eff = (cursor_width_r > cur_ovl_pkg::SIZE_W'(cur_ovl_pkg::MAX_CURSOR_WIDTH))
          ? cur_ovl_pkg::SIZE_W'(cur_ovl_pkg::MAX_CURSOR_WIDTH) : cursor_width_r;
    h_eff = (cursor_height_r > cur_ovl_pkg::SIZE_W'(cur_ovl_pkg::MAX_CURSOR_HEIGHT))
          ? cur_ovl_pkg::SIZE_W'(cur_ovl_pkg::MAX_CURSOR_HEIGHT) : cursor_height_r;
    dx = $signed({2'b00, in_pos_x}) - $signed({cursor_x_r[cur_ovl_pkg::CRD_W-1], cursor_x_r});
    dy = $signed({2'b00, in_pos_y}) - $signed({cursor_y_r[cur_ovl_pkg::CRD_W-1], cursor_y_r});
    hit0 = cursor_visible_r && (w_eff != '0) && (h_eff != '0)
        && !dx[cur_ovl_pkg::DIFF_W-1] && !dy[cur_ovl_pkg::DIFF_W-1]
        && (dx[cur_ovl_pkg::DIFF_W-2:0] < (cur_ovl_pkg::DIFF_W-1)'(w_eff))
        && (dy[cur_ovl_pkg::DIFF_W-2:0] < (cur_ovl_pkg::DIFF_W-1)'(h_eff));
    bg0 = bg_rgb565_r ? expand_565(in_pixel_word[15:0]) : in_pixel_word;
    ram_raddr = cur_ovl_pkg::BMP_ADDR_W'(dy[cur_ovl_pkg::ROW_W-1:0])
              * cur_ovl_pkg::BMP_ADDR_W'(cur_ovl_pkg::MAX_CURSOR_WIDTH)
              + cur_ovl_pkg::BMP_ADDR_W'(dx[cur_ovl_pkg::COL_W-1:0]);
    ram_waddr = cur_ovl_pkg::BMP_ADDR_W'(in_pos_y[cur_ovl_pkg::ROW_W-1:0])
              * cur_ovl_pkg::BMP_ADDR_W'(cur_ovl_pkg::MAX_CURSOR_WIDTH)
              + cur_ovl_pkg::BMP_ADDR_W'(in_pos_x[cur_ovl_pkg::COL_W-1:0]);
    ram_we = in_acc && is_load
        && (in_pos_x < cur_ovl_pkg::POS_W'(cur_ovl_pkg::MAX_CURSOR_WIDTH))
        && (in_pos_y < cur_ovl_pkg::POS_W'(cur_ovl_pkg::MAX_CURSOR_HEIGHT));
  end

  // cursor bitmap; read data lines up with stage 1
  logic [cur_ovl_pkg::PIX_W-1:0] bmp_word;

  cur_ovl_ram #(
    .WIDTH (cur_ovl_pkg::PIX_W),
    .DEPTH (cur_ovl_pkg::BMP_DEPTH)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_pixel_word),
    .re    (en1),
    .raddr (ram_raddr),
    .rdata (bmp_word)
  );

  // ---- stage 1 registers ----
  logic                          hit1_r;
  logic [cur_ovl_pkg::PIX_W-1:0] bg1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_acc && is_comp;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      hit1_r <= hit0;
      bg1_r  <= bg0;
    end
  end

  // ---- stage 1: colour key, alpha test, channel products ----
  cur_ovl_pkg::comp_mode_t mode1;
  logic [15:0]             sum_r1, sum_g1, sum_b1;

  always_comb begin
    priority if (!hit1_r || bmp_word == key_color_r) begin
      mode1 = cur_ovl_pkg::MODE_BG;
    end else if (bmp_word[31:24] == cur_ovl_pkg::ALPHA_OPAQUE) begin
      mode1 = cur_ovl_pkg::MODE_WORD;
    end else begin
      mode1 = cur_ovl_pkg::MODE_BLEND;
    end
    sum_r1 = blend_sum(bmp_word[23:16], bg1_r[23:16], bmp_word[31:24]);
    sum_g1 = blend_sum(bmp_word[15:8],  bg1_r[15:8],  bmp_word[31:24]);
    sum_b1 = blend_sum(bmp_word[7:0],   bg1_r[7:0],   bmp_word[31:24]);
  end

  // ---- stage 2 registers ----
  cur_ovl_pkg::comp_mode_t       mode2_r;
  logic                          hit2_r;
  logic [cur_ovl_pkg::PIX_W-1:0] bg2_r, word2_r;
  logic [15:0]                   sum_r2_r, sum_g2_r, sum_b2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      mode2_r  <= mode1;
      hit2_r   <= hit1_r;
      bg2_r    <= bg1_r;
      word2_r  <= bmp_word;
      sum_r2_r <= sum_r1;
      sum_g2_r <= sum_g1;
      sum_b2_r <= sum_b1;
    end
  end

  // ---- stage 2: divide and select ----
  logic [cur_ovl_pkg::PIX_W-1:0] pixel2;

  always_comb begin
    unique case (mode2_r)
      cur_ovl_pkg::MODE_WORD:  pixel2 = word2_r;
      cur_ovl_pkg::MODE_BLEND: pixel2 = {cur_ovl_pkg::ALPHA_OPAQUE, div255(sum_r2_r),
                                         div255(sum_g2_r), div255(sum_b2_r)};
      default:                 pixel2 = bg2_r;
    endcase
  end

  // ---- output register ----
  logic [cur_ovl_pkg::PIX_W-1:0] out_pixel_r;
  logic                          out_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_pixel_r <= pixel2;
      out_hit_r   <= hit2_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pixel_r;
  assign out_tuser  = out_hit_r;

endmodule

>>> rtl/cur_ovl_chk.sv
// Port-level checker for the cursor overlay, bound to the top level.
module cur_ovl_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [cur_ovl_pkg::PIX_W-1:0]      out_tdata,
  input logic                               out_tuser,
  input logic                               cfg_we,
  input logic [cur_ovl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [cur_ovl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // composite beats accepted but not yet delivered
  logic [2:0] pending_r;
  logic       comp_in, res_out;
  logic       vis_r, rgb565_r;

  assign comp_in = in_tvalid && in_tready
                && (cur_ovl_pkg::req_type_t'(in_tuser) == cur_ovl_pkg::REQ_COMPOSITE);
  assign res_out = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + {2'b00, comp_in} - {2'b00, res_out};
    end
  end

  // shadow of the visibility and background format registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_r    <= 1'b0;
      rgb565_r <= 1'b0;
    end else if (cfg_we) begin
      if (cur_ovl_pkg::cfg_idx_t'(cfg_index) == cur_ovl_pkg::CFG_VISIBLE) begin
        vis_r <= cfg_wdata[0];
      end
      if (cur_ovl_pkg::cfg_idx_t'(cfg_index) == cur_ovl_pkg::CFG_BG_RGB565) begin
        rgb565_r <= cfg_wdata[0];
      end
    end
  end

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // every result beat belongs to an accepted composite beat; loads give none
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pending_r != 3'd0)
    else $error("result beat without a composite beat");

  // a hidden cursor is never hit
  a_hidden: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> vis_r)
    else $error("cursor hit while hidden");

  // an RGB565 background outside the cursor comes out opaque
  a_565_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && rgb565_r |-> out_tdata[31:24] == cur_ovl_pkg::ALPHA_OPAQUE)
    else $error("expanded RGB565 background not opaque");

endmodule

bind cursor_overlay_compositor_top cur_ovl_chk u_cur_ovl_chk (.*);

>>> bench/testbench.sv
// Self-checking bench for the cursor overlay compositor: directed cases, then random traffic.
`timescale 1ns / 100ps

module testbench;

  localparam int TAIL_CYCLES = 8;    // pipeline is 3 deep, leave some slack
  localparam int PARK_CYCLES = 250;  // long output hold-off

  typedef struct {
    logic [cur_ovl_pkg::PIX_W-1:0] pixel;
    logic                          hit;
  } pixel_result_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [cur_ovl_pkg::IN_DATA_W-1:0]   in_tdata = '0;   // pos_x, pos_y, pixel_word
  logic                                in_tuser = 1'b0; // req_type
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [cur_ovl_pkg::PIX_W-1:0]       out_tdata;       // out_pixel
  logic                                out_tuser;       // cursor_hit
  logic                                cfg_we = 1'b0;
  logic [cur_ovl_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [cur_ovl_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Mirror of the block's registers and bitmap store
  logic signed [cur_ovl_pkg::CRD_W-1:0] mir_cur_x = '0;
  logic signed [cur_ovl_pkg::CRD_W-1:0] mir_cur_y = '0;
  logic [cur_ovl_pkg::SIZE_W-1:0]       mir_cur_w = '0;
  logic [cur_ovl_pkg::SIZE_W-1:0]       mir_cur_h = '0;
  logic [cur_ovl_pkg::PIX_W-1:0]        mir_key = '0;
  logic                                 mir_visible = 1'b0;
  logic                                 mir_rgb565 = 1'b0;
  logic [cur_ovl_pkg::PIX_W-1:0]        mir_bitmap [cur_ovl_pkg::BMP_DEPTH];
  bit                                   mir_loaded [cur_ovl_pkg::BMP_DEPTH];

  pixel_result_t expected_pixels[$];
  int fail_count = 0;
  int beats_sent = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int park_req = 0;

  cursor_overlay_compositor_top DUT (.*);

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  // Bitmap slot under a screen pixel, or -1 when the pixel misses the cursor
  function automatic int cursor_slot(logic [cur_ovl_pkg::POS_W-1:0] px,
                                     logic [cur_ovl_pkg::POS_W-1:0] py);
    int w, h, dx, dy;
    w = (mir_cur_w > cur_ovl_pkg::MAX_CURSOR_WIDTH) ? cur_ovl_pkg::MAX_CURSOR_WIDTH
                                                     : int'(mir_cur_w);
    h = (mir_cur_h > cur_ovl_pkg::MAX_CURSOR_HEIGHT) ? cur_ovl_pkg::MAX_CURSOR_HEIGHT
                                                      : int'(mir_cur_h);
    dx = int'(px) - int'(mir_cur_x);
    dy = int'(py) - int'(mir_cur_y);
    if (!mir_visible || w == 0 || h == 0 || dx < 0 || dx >= w || dy < 0 || dy >= h)
      return -1;
    return dy * cur_ovl_pkg::MAX_CURSOR_WIDTH + dx;
  endfunction

  function automatic logic [cur_ovl_pkg::PIX_W-1:0] widen_background(
      logic [cur_ovl_pkg::PIX_W-1:0] word);
    logic [4:0] r5, b5;
    logic [5:0] g6;
    if (!mir_rgb565) return word;
    r5 = word[15:11];
    g6 = word[10:5];
    b5 = word[4:0];
    return {cur_ovl_pkg::ALPHA_OPAQUE, r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
  endfunction

  function automatic logic [7:0] mix_channel(logic [7:0] fg, logic [7:0] bg, logic [7:0] a);
    int acc;
    acc = int'(fg) * int'(a) + int'(bg) * (255 - int'(a)) + 127;
    return 8'(acc / 255);
  endfunction

  function automatic pixel_result_t predict_pixel(logic [cur_ovl_pkg::POS_W-1:0] px,
                                                  logic [cur_ovl_pkg::POS_W-1:0] py,
                                                  logic [cur_ovl_pkg::PIX_W-1:0] word);
    pixel_result_t res;
    int slot;
    logic [cur_ovl_pkg::PIX_W-1:0] bg, fgw;
    logic [7:0] a;
    slot = cursor_slot(px, py);
    bg = widen_background(word);
    res.hit = (slot >= 0);
    res.pixel = bg;
    if (res.hit) begin
      fgw = mir_bitmap[slot];
      a = fgw[31:24];
      if (fgw == mir_key) res.pixel = bg;
      else if (a == cur_ovl_pkg::ALPHA_OPAQUE) res.pixel = fgw;
      else res.pixel = {cur_ovl_pkg::ALPHA_OPAQUE, mix_channel(fgw[23:16], bg[23:16], a),
                        mix_channel(fgw[15:8], bg[15:8], a), mix_channel(fgw[7:0], bg[7:0], a)};
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- helpers

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [cur_ovl_pkg::POS_W-1:0] clamp_coord(int v);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return cur_ovl_pkg::POS_W'(v);
  endfunction

  // coordinate in or just around the cursor span
  function automatic logic [cur_ovl_pkg::POS_W-1:0] near_coord(
      logic signed [cur_ovl_pkg::CRD_W-1:0] origin, logic [cur_ovl_pkg::SIZE_W-1:0] size);
    int off;
    off = $urandom_range(int'(size) + 3);
    return clamp_coord(int'(origin) + off - 2);
  endfunction

  function automatic logic [cur_ovl_pkg::PIX_W-1:0] random_cursor_word();
    logic [cur_ovl_pkg::PIX_W-1:0] w;
    w = $urandom;
    case ($urandom_range(5))
      0: w[31:24] = 8'h00;
      1: w[31:24] = cur_ovl_pkg::ALPHA_OPAQUE;
      2: w = mir_key;
      default: ;
    endcase
    return w;
  endfunction

  function automatic int pick_size();
    case ($urandom_range(7))
      0: return 0;
      1: return cur_ovl_pkg::MAX_CURSOR_WIDTH;
      2: return 63;
      3: return $urandom_range(33, 63);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  task automatic idle_gap(int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // wait until every result is back, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // one input beat; valid stays high for a following beat
  task automatic send_beat(cur_ovl_pkg::req_type_t kind, logic [cur_ovl_pkg::POS_W-1:0] px,
                           logic [cur_ovl_pkg::POS_W-1:0] py,
                           logic [cur_ovl_pkg::PIX_W-1:0] word);
    int slot;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {word, py, px};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    if (kind == cur_ovl_pkg::REQ_LOAD) begin
      if (px < cur_ovl_pkg::MAX_CURSOR_WIDTH && py < cur_ovl_pkg::MAX_CURSOR_HEIGHT) begin
        slot = int'(py) * cur_ovl_pkg::MAX_CURSOR_WIDTH + int'(px);
        mir_bitmap[slot] = word;
        mir_loaded[slot] = 1'b1;
      end
    end else begin
      expected_pixels.push_back(predict_pixel(px, py, word));
    end
    if ($urandom_range(99) < tx_idle_pct) idle_gap(pick_gap());
  endtask

  // composite beat; an unwritten bitmap slot under it is loaded first
  task automatic send_pixel(logic [cur_ovl_pkg::POS_W-1:0] px,
                            logic [cur_ovl_pkg::POS_W-1:0] py,
                            logic [cur_ovl_pkg::PIX_W-1:0] word);
    int slot;
    slot = cursor_slot(px, py);
    if (slot >= 0 && !mir_loaded[slot])
      send_beat(cur_ovl_pkg::REQ_LOAD,
                cur_ovl_pkg::POS_W'(slot % cur_ovl_pkg::MAX_CURSOR_WIDTH),
                cur_ovl_pkg::POS_W'(slot / cur_ovl_pkg::MAX_CURSOR_WIDTH),
                random_cursor_word());
    send_beat(cur_ovl_pkg::REQ_COMPOSITE, px, py, word);
  endtask

  // register write, only with the block idle
  task automatic write_reg(cur_ovl_pkg::cfg_idx_t idx,
                           logic [cur_ovl_pkg::CFG_DATA_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cur_ovl_pkg::CFG_CURSOR_X:      mir_cur_x = value[cur_ovl_pkg::CRD_W-1:0];
      cur_ovl_pkg::CFG_CURSOR_Y:      mir_cur_y = value[cur_ovl_pkg::CRD_W-1:0];
      cur_ovl_pkg::CFG_CURSOR_WIDTH:  mir_cur_w = value[cur_ovl_pkg::SIZE_W-1:0];
      cur_ovl_pkg::CFG_CURSOR_HEIGHT: mir_cur_h = value[cur_ovl_pkg::SIZE_W-1:0];
      cur_ovl_pkg::CFG_KEY_COLOR:     mir_key = value;
      cur_ovl_pkg::CFG_VISIBLE:       mir_visible = value[0];
      cur_ovl_pkg::CFG_BG_RGB565:     mir_rgb565 = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_cursor(int x, int y, int w, int h, bit vis);
    write_reg(cur_ovl_pkg::CFG_CURSOR_X, x & 32'h1FFF);
    write_reg(cur_ovl_pkg::CFG_CURSOR_Y, y & 32'h1FFF);
    write_reg(cur_ovl_pkg::CFG_CURSOR_WIDTH, w & 32'h3F);
    write_reg(cur_ovl_pkg::CFG_CURSOR_HEIGHT, h & 32'h3F);
    write_reg(cur_ovl_pkg::CFG_VISIBLE, cur_ovl_pkg::CFG_DATA_W'(vis));
  endtask

  // random mix: loads, composites around the cursor, scan lines and noise
  task automatic run_stream(int count);
    int stop, pick, span;
    logic [cur_ovl_pkg::POS_W-1:0] row;
    stop = beats_sent + count;
    while (beats_sent < stop) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        send_beat(cur_ovl_pkg::REQ_LOAD,
                  cur_ovl_pkg::POS_W'($urandom_range(cur_ovl_pkg::MAX_CURSOR_WIDTH - 1)),
                  cur_ovl_pkg::POS_W'($urandom_range(cur_ovl_pkg::MAX_CURSOR_HEIGHT - 1)),
                  random_cursor_word());
      end else if (pick < 15) begin
        send_beat(cur_ovl_pkg::REQ_LOAD, cur_ovl_pkg::POS_W'($urandom),
                  cur_ovl_pkg::POS_W'($urandom), $urandom);
      end else if (pick < 30) begin
        send_pixel(cur_ovl_pkg::POS_W'($urandom), cur_ovl_pkg::POS_W'($urandom), $urandom);
      end else if (pick < 36) begin
        // one scan line across the cursor and a little either side
        span = (mir_cur_w > cur_ovl_pkg::MAX_CURSOR_WIDTH) ? cur_ovl_pkg::MAX_CURSOR_WIDTH
                                                            : int'(mir_cur_w);
        row = near_coord(mir_cur_y, mir_cur_h);
        for (int i = -2; i < span + 2; i++)
          send_pixel(clamp_coord(int'(mir_cur_x) + i), row, $urandom);
      end else begin
        send_pixel(near_coord(mir_cur_x, mir_cur_w), near_coord(mir_cur_y, mir_cur_h), $urandom);
      end
    end
  endtask

  task automatic random_setup();
    int x, y;
    case ($urandom_range(4))
      0: begin x = -4096; y = -4096; end
      1: begin x = 4095;  y = 4095;  end
      2: begin
        x = int'($urandom_range(8191)) - 4096;
        y = int'($urandom_range(8191)) - 4096;
      end
      default: begin
        x = int'($urandom_range(60)) - 20;
        y = int'($urandom_range(60)) - 20;
      end
    endcase
    set_cursor(x, y, pick_size(), pick_size(), $urandom_range(99) < 85);
    case ($urandom_range(3))
      0: write_reg(cur_ovl_pkg::CFG_KEY_COLOR, 32'hFFFF_FFFF);
      1: write_reg(cur_ovl_pkg::CFG_KEY_COLOR, 32'h0000_0000);
      default: write_reg(cur_ovl_pkg::CFG_KEY_COLOR, $urandom);
    endcase
    write_reg(cur_ovl_pkg::CFG_BG_RGB565, cur_ovl_pkg::CFG_DATA_W'($urandom_range(1)));
  endtask

  // ---------------------------------------------------------------- tests

  // registers at reset: cursor hidden, everything passes through
  task automatic test_reset_defaults();
    send_beat(cur_ovl_pkg::REQ_COMPOSITE, 12'd0, 12'd0, 32'hDEAD_BEEF);
    send_beat(cur_ovl_pkg::REQ_COMPOSITE, 12'd4095, 12'd4095, 32'h0000_0000);
    send_beat(cur_ovl_pkg::REQ_COMPOSITE, 12'd0, 12'd4095, 32'hFFFF_FFFF);
  endtask

  // colour key, opaque copy, blends and both background formats
  task automatic test_compositing_rules();
    set_cursor(4, 2, 4, 2, 1'b1);
    write_reg(cur_ovl_pkg::CFG_KEY_COLOR, 32'h8011_2233);
    write_reg(cur_ovl_pkg::CFG_BG_RGB565, 32'd0);
    send_beat(cur_ovl_pkg::REQ_LOAD, 12'd0, 12'd0, 32'h8011_2233);
    send_beat(cur_ovl_pkg::REQ_LOAD, 12'd1, 12'd0, 32'hFF33_6699);
    send_beat(cur_ovl_pkg::REQ_LOAD, 12'd2, 12'd0, 32'h00AB_CDEF);
    send_beat(cur_ovl_pkg::REQ_LOAD, 12'd3, 12'd0, 32'h80FF_0080);
    send_beat(cur_ovl_pkg::REQ_LOAD, 12'd0, 12'd1, 32'h01FF_FFFF);
    // out-of-range loads must leave slot 0 alone
    send_beat(cur_ovl_pkg::REQ_LOAD, 12'd32, 12'd0, 32'h7F00_0000);
    send_beat(cur_ovl_pkg::REQ_LOAD, 12'd0, 12'd32, 32'h7F00_0000);
    send_beat(cur_ovl_pkg::REQ_LOAD, 12'd4095, 12'd4095, 32'h7F00_0000);
    send_beat(cur_ovl_pkg::REQ_COMPOSITE, 12'd4, 12'd2, 32'h0012_3456);
    send_beat(cur_ovl_pkg::REQ_COMPOSITE, 12'd5, 12'd2, 32'hFFFF_FFFF);
    send_beat(cur_ovl_pkg::REQ_COMPOSITE, 12'd6, 12'd2, 32'h5A5A_5A5A);
    send_beat(cur_ovl_pkg::REQ_COMPOSITE, 12'd7, 12'd2, 32'h0000_0000);
    send_beat(cur_ovl_pkg::REQ_COMPOSITE, 12'd4, 12'd3, 32'hFFFF_FFFF);
    send_beat(cur_ovl_pkg::REQ_COMPOSITE, 12'd8, 12'd2, 32'h1357_9BDF);
    send_beat(cur_ovl_pkg::REQ_COMPOSITE, 12'd3, 12'd3, 32'h2468_ACE0);
    write_reg(cur_ovl_pkg::CFG_BG_RGB565, 32'd1);
    send_beat(cur_ovl_pkg::REQ_COMPOSITE, 12'd7, 12'd2, 32'hFFFF_F81F);
    send_beat(cur_ovl_pkg::REQ_COMPOSITE, 12'd4, 12'd2, 32'hA5A5_07E0);
    send_beat(cur_ovl_pkg::REQ_COMPOSITE, 12'd9, 12'd9, 32'h1234_FFFF);
  endtask

  // clamped sizes, off-screen origins, screen corners, hidden and empty cursor
  task automatic test_cursor_geometry();
    set_cursor(0, 0, 63, 63, 1'b1);
    send_pixel(12'd31, 12'd31, $urandom);
    send_pixel(12'd32, 12'd5, $urandom);
    send_pixel(12'd5, 12'd32, $urandom);
    set_cursor(-2, -1, 4, 4, 1'b1);
    send_pixel(12'd0, 12'd0, $urandom);
    send_pixel(12'd1, 12'd2, $urandom);
    set_cursor(4095, 4095, 1, 1, 1'b1);
    send_pixel(12'd4095, 12'd4095, $urandom);
    send_pixel(12'd4094, 12'd4095, $urandom);
    set_cursor(-4096, -4096, 32, 32, 1'b1);
    send_pixel(12'd0, 12'd0, $urandom);
    set_cursor(0, 0, 0, 8, 1'b1);
    send_pixel(12'd0, 12'd0, $urandom);
    set_cursor(0, 0, 8, 8, 1'b0);
    send_pixel(12'd0, 12'd0, $urandom);
  endtask

  // receiver parks for a long stretch while the sender keeps offering beats
  task automatic test_output_stall();
    set_cursor(10, 10, 8, 8, 1'b1);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    park_req = PARK_CYCLES;
    run_stream(80);
  endtask

  // sender stops until all results are back, then resumes
  task automatic test_sender_pause();
    tx_idle_pct = 10;
    rx_stall_pct = 30;
    run_stream(30);
    drain();
    run_stream(30);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 10; phase++) begin
      random_setup();
      if (phase == 0) begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end else begin
        tx_idle_pct = 15 * $urandom_range(3);
        rx_stall_pct = 15 * $urandom_range(3);
      end
      run_stream(150);
    end
  endtask

  // ---------------------------------------------------------------- processes

  // result side ready pattern
  initial begin : rx_side
    int stall;
    forever begin
      @(posedge clk);
      if (park_req != 0) begin
        stall = park_req;
        park_req = 0;
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_tready <= 1'b1;
      end else if ($urandom_range(99) < rx_stall_pct) begin
        out_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result beat: out_pixel %h cursor_hit %b", out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_tdata !== want.pixel) begin
          $error("out_pixel: expected %h, got %h", want.pixel, out_tdata);
          fail_count++;
        end
        if (out_tuser !== want.hit) begin
          $error("cursor_hit: expected %b, got %b", want.hit, out_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : main_seq
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 20;
    rx_stall_pct = 20;
    test_reset_defaults();
    test_compositing_rules();
    test_cursor_geometry();
    test_output_stall();
    test_sender_pause();
    test_random_traffic();
    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/cur_ovl_pkg.sv
rtl/cur_ovl_ram.sv
rtl/cursor_overlay_compositor_top.sv
rtl/cur_ovl_chk.sv
bench/testbench.sv
